/* src/ntrl_pkg.sv */
package ntrl_pkg;

    localparam int DEPTH   = 64;
    localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW      = $clog2(DEPTH + 1);
    localparam int STAMP_W = 48;
    localparam int VEL_W   = 32;
    localparam int TOL_W   = 24;
    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(100000);

    localparam int QDEPTH = 2;
    localparam int QAW    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCW    = $clog2(QDEPTH + 1);

    localparam logic CMD_PUSH  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [1:0] ST_FOUND = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_EARLY = 2'd2;
    localparam logic [1:0] ST_LATE  = 2'd3;

    typedef struct packed {
        logic signed [VEL_W-1:0] x;
        logic signed [VEL_W-1:0] y;
        logic signed [VEL_W-1:0] z;
    } vel_t;

    typedef struct packed {
        logic                 is_query;
        logic [STAMP_W-1:0]   stamp;
        vel_t                 vel;
    } item_t;

    typedef struct packed {
        logic push;
        logic full;
    } qwr_t;

    typedef struct packed {
        logic pop;
        logic empty;
    } qrd_t;

    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                              input logic [AW-1:0] logical);
        logic [AW:0] sum;
        sum = {1'b0, base} + {1'b0, logical};
        if (sum >= (AW+1)'(DEPTH))
            sum = sum - (AW+1)'(DEPTH);
        return sum[AW-1:0];
    endfunction

endpackage

/* src/nearest_timestamp_ring_lookup_core.sv */
// channel   direction  handshake              beat
// input     in         push / full            cmd, stamp, vel_x, vel_y, vel_z
// result    out        empty / pop            status, out_vel_x, out_vel_y, out_vel_z
// config    in         cfg_we                 match_tolerance
//
// a push beat is written to the store as it leaves the two-entry queue
// a query runs S_NEW, S_OLD, then up to 63 walk steps, one stored stamp read a cycle;
// a query on an empty store goes straight to S_EMIT
// the input stage and queue keep taking beats while a query walks the store, until both are full
// a finished result waits in the output register; the next result waits in S_EMIT until it is popped
// reset clears pointers and fill count and sets tolerance to TOL_RESET; the store itself is not cleared
module nearest_timestamp_ring_lookup_core
    import ntrl_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [TOL_W-1:0]          match_tolerance,
    input  logic                      push,
    output logic                      full,
    input  logic                      cmd,
    input  logic [STAMP_W-1:0]        stamp,
    input  logic signed [VEL_W-1:0]   vel_x,
    input  logic signed [VEL_W-1:0]   vel_y,
    input  logic signed [VEL_W-1:0]   vel_z,
    output logic                      empty,
    input  logic                      pop,
    output logic [1:0]                status,
    output logic signed [VEL_W-1:0]   out_vel_x,
    output logic signed [VEL_W-1:0]   out_vel_y,
    output logic signed [VEL_W-1:0]   out_vel_z
);

    qwr_t  q_wr_ctl;
    qrd_t  q_rd_ctl;
    logic  q_full;
    logic  q_pop;
    item_t wr_item;
    item_t rd_item;

    ntrl_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .cmd      (cmd),
        .stamp    (stamp),
        .vel_x    (vel_x),
        .vel_y    (vel_y),
        .vel_z    (vel_z),
        .q_wr_ctl (q_wr_ctl),
        .q_full   (q_full),
        .q_item   (wr_item)
    );

    ntrl_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_ctl  (q_wr_ctl),
        .wr_item (wr_item),
        .full    (q_full),
        .pop     (q_pop),
        .rd_ctl  (q_rd_ctl),
        .rd_item (rd_item)
    );

    ntrl_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .match_tolerance (match_tolerance),
        .q_rd_ctl        (q_rd_ctl),
        .q_item          (rd_item),
        .q_pop           (q_pop),
        .empty           (empty),
        .pop             (pop),
        .status          (status),
        .out_vel_x       (out_vel_x),
        .out_vel_y       (out_vel_y),
        .out_vel_z       (out_vel_z)
    );

endmodule

/* src/ntrl_front.sv */
module ntrl_front
    import ntrl_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic                      cmd,
    input  logic [STAMP_W-1:0]        stamp,
    input  logic signed [VEL_W-1:0]   vel_x,
    input  logic signed [VEL_W-1:0]   vel_y,
    input  logic signed [VEL_W-1:0]   vel_z,
    output qwr_t                      q_wr_ctl,
    input  logic                      q_full,
    output item_t                     q_item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  accept;
    logic  fwd;

    assign fwd    = valid_reg && !q_full;
    assign full   = valid_reg && q_full;
    assign accept = push && !full;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
            valid_next = 1'b1;
        else if (fwd)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // classify the beat on entry
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.is_query <= (cmd == CMD_QUERY);
            item_reg.stamp    <= stamp;
            item_reg.vel.x    <= vel_x;
            item_reg.vel.y    <= vel_y;
            item_reg.vel.z    <= vel_z;
        end
    end

    assign q_wr_ctl.push = fwd;
    assign q_wr_ctl.full = q_full;
    assign q_item        = item_reg;

endmodule

/* src/ntrl_fifo.sv */
module ntrl_fifo
    import ntrl_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  qwr_t  wr_ctl,
    input  item_t wr_item,
    output logic  full,
    input  logic  pop,
    output qrd_t  rd_ctl,
    output item_t rd_item
);

    item_t            mem [QDEPTH];
    logic [QAW-1:0]   wr_ptr_reg;
    logic [QAW-1:0]   wr_ptr_next;
    logic [QAW-1:0]   rd_ptr_reg;
    logic [QAW-1:0]   rd_ptr_next;
    logic [QCW-1:0]   count_reg;
    logic [QCW-1:0]   count_next;
    logic             do_wr;
    logic             do_rd;
    logic             empty;

    assign full  = (count_reg == QCW'(QDEPTH));
    assign empty = (count_reg == '0);
    assign do_wr = wr_ctl.push && !full;
    assign do_rd = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_wr && !do_rd)
            count_next = count_reg + 1'b1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem[wr_ptr_reg] <= wr_item;
    end

    assign rd_ctl.pop   = do_rd;
    assign rd_ctl.empty = empty;
    assign rd_item      = mem[rd_ptr_reg];

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        wr_ctl.push |-> !wr_ctl.full)
        else $error("beat forwarded into a full queue");

endmodule

/* src/ntrl_back.sv */
module ntrl_back
    import ntrl_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [TOL_W-1:0]          match_tolerance,
    input  qrd_t                      q_rd_ctl,
    input  item_t                     q_item,
    output logic                      q_pop,
    output logic                      empty,
    input  logic                      pop,
    output logic [1:0]                status,
    output logic signed [VEL_W-1:0]   out_vel_x,
    output logic signed [VEL_W-1:0]   out_vel_y,
    output logic signed [VEL_W-1:0]   out_vel_z
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_NEW  = 3'd1;
    localparam logic [2:0] S_OLD  = 3'd2;
    localparam logic [2:0] S_WALK = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;

    logic [STAMP_W-1:0] time_mem [DEPTH];
    vel_t               vel_mem  [DEPTH];
    logic [STAMP_W-1:0] time_rd_reg;
    vel_t               vel_rd_reg;

    logic [2:0]         state_reg,  state_next;
    logic [CW-1:0]      fill_reg,   fill_next;
    logic [AW-1:0]      oldest_reg, oldest_next;
    logic [AW-1:0]      k_reg,      k_next;
    logic [TOL_W-1:0]   tol_reg;
    logic [STAMP_W-1:0] q_stamp_reg, q_stamp_next;
    logic [STAMP_W-1:0] newest_reg,  newest_next;
    logic [STAMP_W-1:0] dist_reg,    dist_next;
    vel_t               best_vel_reg, best_vel_next;
    logic [1:0]         res_status_reg, res_status_next;
    logic               out_valid_reg, out_valid_next;
    logic [1:0]         out_status_reg;
    vel_t               out_vel_reg;

    logic               wr_en;
    logic [AW-1:0]      wr_slot;
    logic [AW-1:0]      rd_addr;
    logic [AW-1:0]      newest_logical;
    logic               load_out;
    logic               too_early;
    logic               too_late;
    logic [STAMP_W-1:0] gap_newest;
    logic [STAMP_W-1:0] gap_cand;

    function automatic logic [STAMP_W-1:0] abs_gap(input logic [STAMP_W-1:0] a,
                                                   input logic [STAMP_W-1:0] b);
        return (a >= b) ? a - b : b - a;
    endfunction

    assign newest_logical = AW'(fill_reg - 1'b1);
    assign q_pop   = (state_reg == S_IDLE) && !q_rd_ctl.empty;
    assign wr_en   = q_pop && !q_item.is_query;
    assign wr_slot = (fill_reg < CW'(DEPTH)) ? slot_of(oldest_reg, AW'(fill_reg))
                                             : oldest_reg;

    assign too_early  = {1'b0, time_rd_reg} > ({1'b0, q_stamp_reg} + (STAMP_W+1)'(tol_reg));
    assign too_late   = ({1'b0, newest_reg} + (STAMP_W+1)'(tol_reg)) < {1'b0, q_stamp_reg};
    assign gap_newest = abs_gap(q_stamp_reg, newest_reg);
    assign gap_cand   = abs_gap(q_stamp_reg, time_rd_reg);
    assign load_out   = (state_reg == S_EMIT) && (!out_valid_reg || pop);

    always_comb
    begin
        case (state_reg)
            S_IDLE:  rd_addr = slot_of(oldest_reg, newest_logical);
            S_NEW:   rd_addr = oldest_reg;
            S_OLD:   rd_addr = slot_of(oldest_reg, k_reg - 1'b1);
            S_WALK:  rd_addr = slot_of(oldest_reg, k_reg - AW'(2));
            default: rd_addr = oldest_reg;
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        fill_next       = fill_reg;
        oldest_next     = oldest_reg;
        k_next          = k_reg;
        q_stamp_next    = q_stamp_reg;
        newest_next     = newest_reg;
        dist_next       = dist_reg;
        best_vel_next   = best_vel_reg;
        res_status_next = res_status_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (q_pop)
                begin
                    if (!q_item.is_query)
                    begin
                        if (fill_reg < CW'(DEPTH))
                            fill_next = fill_reg + 1'b1;
                        else
                            oldest_next = slot_of(oldest_reg, AW'(1));
                    end
                    else
                    begin
                        q_stamp_next = q_item.stamp;
                        k_next       = newest_logical;
                        if (fill_reg == '0)
                        begin
                            res_status_next = ST_EMPTY;
                            state_next      = S_EMIT;
                        end
                        else
                            state_next = S_NEW;
                    end
                end
            end
            S_NEW:
            begin
                newest_next   = time_rd_reg;
                best_vel_next = vel_rd_reg;
                state_next    = S_OLD;
            end
            S_OLD:
            begin
                dist_next = gap_newest;
                if (too_early)
                begin
                    res_status_next = ST_EARLY;
                    state_next      = S_EMIT;
                end
                else if (too_late)
                begin
                    res_status_next = ST_LATE;
                    state_next      = S_EMIT;
                end
                else if (k_reg == '0)
                begin
                    res_status_next = ST_FOUND;
                    state_next      = S_EMIT;
                end
                else
                    state_next = S_WALK;
            end
            S_WALK:
            begin
                if (gap_cand < dist_reg)
                begin
                    dist_next     = gap_cand;
                    best_vel_next = vel_rd_reg;
                    k_next        = k_reg - 1'b1;
                    if (k_reg == AW'(1))
                    begin
                        res_status_next = ST_FOUND;
                        state_next      = S_EMIT;
                    end
                end
                else
                begin
                    res_status_next = ST_FOUND;
                    state_next      = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (load_out)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
            out_valid_next = 1'b1;
        else if (pop)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            oldest_reg    <= '0;
            tol_reg       <= TOL_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            oldest_reg    <= oldest_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
                tol_reg <= match_tolerance;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg          <= k_next;
        q_stamp_reg    <= q_stamp_next;
        newest_reg     <= newest_next;
        dist_reg       <= dist_next;
        best_vel_reg   <= best_vel_next;
        res_status_reg <= res_status_next;
        if (load_out)
        begin
            out_status_reg <= res_status_reg;
            out_vel_reg    <= (res_status_reg == ST_FOUND) ? best_vel_reg : '0;
        end
    end

    // sample store, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            time_mem[wr_slot] <= q_item.stamp;
            vel_mem[wr_slot]  <= q_item.vel;
        end
        time_rd_reg <= time_mem[rd_addr];
        vel_rd_reg  <= vel_mem[rd_addr];
    end

    assign empty     = !out_valid_reg;
    assign status    = out_status_reg;
    assign out_vel_x = out_vel_reg.x;
    assign out_vel_y = out_vel_reg.y;
    assign out_vel_z = out_vel_reg.z;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CW'(DEPTH))
        else $error("fill count beyond store depth");

    a_oldest_moves_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg < CW'(DEPTH)) |-> (oldest_reg == '0))
        else $error("oldest slot moved before store filled");

    a_walk_index: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |-> (k_reg != '0) && (CW'(k_reg) < fill_reg))
        else $error("walk index out of range");

    a_miss_zero_vel: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_status_reg != ST_FOUND)) |-> (out_vel_reg == '0))
        else $error("velocity not cleared on miss");

    a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !q_rd_ctl.pop)
        else $error("queue popped while a query is in progress");

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps

module tb;
    import ntrl_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 200;
    localparam int MAX_REPORTS   = 50;

    typedef struct packed {
        logic [1:0] status;
        vel_t       vel;
    } lookup_result_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    cfg_we = 1'b0;
    logic [TOL_W-1:0]        match_tolerance = '0;
    logic                    push = 1'b0;
    logic                    full;
    logic                    cmd = CMD_PUSH;
    logic [STAMP_W-1:0]      stamp = '0;
    logic signed [VEL_W-1:0] vel_x = '0;
    logic signed [VEL_W-1:0] vel_y = '0;
    logic signed [VEL_W-1:0] vel_z = '0;
    logic                    empty;
    logic                    pop = 1'b0;
    logic [1:0]              status;
    logic signed [VEL_W-1:0] out_vel_x;
    logic signed [VEL_W-1:0] out_vel_y;
    logic signed [VEL_W-1:0] out_vel_z;

    // ring model
    logic [STAMP_W-1:0] ring_stamp [DEPTH];
    vel_t               ring_vel [DEPTH];
    int                 ring_oldest = 0;
    int                 ring_fill = 0;
    logic [TOL_W-1:0]   tol_model = TOL_RESET;

    lookup_result_t     pending_lookups [$];
    logic [STAMP_W-1:0] stream_now = '0;

    int unsigned tx_max = 17;
    int unsigned rx_max = 17;
    int unsigned rx_hold = 0;
    int          cycle_count = 0;
    int          mismatch_count = 0;
    int          beats_sent = 0;
    int          lookups_checked = 0;
    int          input_stalls = 0;
    int          status_seen [4] = '{0, 0, 0, 0};

    nearest_timestamp_ring_lookup_core dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .match_tolerance (match_tolerance),
        .push            (push),
        .full            (full),
        .cmd             (cmd),
        .stamp           (stamp),
        .vel_x           (vel_x),
        .vel_y           (vel_y),
        .vel_z           (vel_z),
        .empty           (empty),
        .pop             (pop),
        .status          (status),
        .out_vel_x       (out_vel_x),
        .out_vel_y       (out_vel_y),
        .out_vel_z       (out_vel_z)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int ring_slot(input int logical);
        return (ring_oldest + logical) % DEPTH;
    endfunction

    function automatic logic [63:0] stamp_gap(input logic [63:0] a, input logic [63:0] b);
        return (a >= b) ? a - b : b - a;
    endfunction

    function automatic logic [STAMP_W-1:0] rand_stamp();
        logic [63:0] r;
        r = {$urandom(), $urandom()};
        return r[STAMP_W-1:0];
    endfunction

    function automatic vel_t rand_vel();
        return vel_t'({$urandom(), $urandom(), $urandom()});
    endfunction

    function automatic void model_beat(input item_t beat);
        lookup_result_t res;
        int             slot;
        int             best;
        int             k;
        logic [63:0]    q;
        logic [63:0]    oldest;
        logic [63:0]    newest;
        logic [63:0]    gap;
        logic [63:0]    best_gap;
        if (!beat.is_query)
        begin
            if (ring_fill < DEPTH)
            begin
                slot = ring_slot(ring_fill);
                ring_fill++;
            end
            else
            begin
                slot = ring_oldest;
                ring_oldest = (ring_oldest + 1) % DEPTH;
            end
            ring_stamp[slot] = beat.stamp;
            ring_vel[slot] = beat.vel;
            return;
        end
        res.status = ST_FOUND;
        res.vel = '0;
        q = 64'(beat.stamp);
        if (ring_fill == 0)
            res.status = ST_EMPTY;
        else
        begin
            oldest = 64'(ring_stamp[ring_slot(0)]);
            newest = 64'(ring_stamp[ring_slot(ring_fill - 1)]);
            if (oldest > q + 64'(tol_model))
                res.status = ST_EARLY;
            else if (newest + 64'(tol_model) < q)
                res.status = ST_LATE;
            else
            begin
                best = ring_fill - 1;
                best_gap = stamp_gap(q, newest);
                for (k = ring_fill - 1; k > 0; k--)
                begin
                    gap = stamp_gap(q, 64'(ring_stamp[ring_slot(k - 1)]));
                    if (gap >= best_gap)
                        break;
                    best_gap = gap;
                    best = k - 1;
                end
                res.vel = ring_vel[ring_slot(best)];
            end
        end
        pending_lookups.insert(pending_lookups.size(), res);
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_count < MAX_REPORTS)
            $display("tb: mismatch at cycle %0d: %s", cycle_count, msg);
        mismatch_count++;
    endtask

    task automatic check_lookup();
        lookup_result_t want;
        if (pending_lookups.size() == 0)
        begin
            report_mismatch($sformatf("result beat with nothing outstanding, status %0d", status));
            return;
        end
        want = pending_lookups.pop_front();
        lookups_checked++;
        status_seen[want.status]++;
        if (status !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", status, want.status));
        if (out_vel_x !== want.vel.x)
            report_mismatch($sformatf("out_vel_x %0d, want %0d", out_vel_x, want.vel.x));
        if (out_vel_y !== want.vel.y)
            report_mismatch($sformatf("out_vel_y %0d, want %0d", out_vel_y, want.vel.y));
        if (out_vel_z !== want.vel.z)
            report_mismatch($sformatf("out_vel_z %0d, want %0d", out_vel_z, want.vel.z));
    endtask

    task automatic send_beat(input logic is_query, input logic [STAMP_W-1:0] st,
                             input vel_t v);
        int unsigned gap;
        item_t       beat;
        gap = $urandom_range(0, tx_max);
        if (gap != 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        beat.is_query = is_query;
        beat.stamp = st;
        beat.vel = v;
        cmd <= is_query;
        stamp <= st;
        vel_x <= v.x;
        vel_y <= v.y;
        vel_z <= v.z;
        push <= 1'b1;
        @(posedge clk);
        while (full)
        begin
            input_stalls++;
            @(posedge clk);
        end
        model_beat(beat);
        beats_sent++;
    endtask

    task automatic drain_and_idle();
        push <= 1'b0;
        while (pending_lookups.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_tolerance(input logic [TOL_W-1:0] value);
        cfg_we <= 1'b1;
        match_tolerance <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        tol_model = value;
    endtask

    task automatic run_stream(input int count, input int unsigned step_max,
                              input int unsigned span);
        int unsigned        pick;
        int                 i;
        int                 k;
        logic [STAMP_W-1:0] a;
        logic [STAMP_W-1:0] q;
        logic [STAMP_W:0]   mid;
        for (i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 99);
            if (ring_fill == 0 || pick < 45)
            begin
                stream_now = stream_now + STAMP_W'($urandom_range(0, step_max));
                send_beat(CMD_PUSH, stream_now, rand_vel());
            end
            else if (pick < 70)
            begin
                a = ring_stamp[ring_slot($urandom_range(0, ring_fill - 1))];
                q = a + STAMP_W'($urandom_range(0, 2 * span)) - STAMP_W'(span);
                send_beat(CMD_QUERY, q, rand_vel());
            end
            else if (pick < 82)
            begin
                // midpoint of neighbours, to land on ties
                k = $urandom_range(0, ring_fill - 1);
                mid = {1'b0, ring_stamp[ring_slot(k)]}
                    + {1'b0, ring_stamp[ring_slot((k == ring_fill - 1) ? k : k + 1)]};
                q = mid[STAMP_W:1];
                send_beat(CMD_QUERY, q, rand_vel());
            end
            else if (pick < 90)
            begin
                if ($urandom_range(0, 1) == 1)
                    q = ring_stamp[ring_slot(ring_fill - 1)] + STAMP_W'(tol_model) + 1
                        + STAMP_W'($urandom_range(0, span));
                else
                    q = ring_stamp[ring_slot(0)] - STAMP_W'(tol_model) - 1
                        - STAMP_W'($urandom_range(0, span));
                send_beat(CMD_QUERY, q, rand_vel());
            end
            else if (pick < 95)
                send_beat(CMD_PUSH, rand_stamp(), rand_vel());
            else
                send_beat(CMD_QUERY, rand_stamp(), rand_vel());
        end
    endtask

    task automatic test_directed();
        // empty store, then a short rising run
        send_beat(CMD_QUERY, '0, rand_vel());
        send_beat(CMD_QUERY, {STAMP_W{1'b1}}, rand_vel());
        send_beat(CMD_PUSH, 48'd1_000_000, {32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000});
        send_beat(CMD_PUSH, 48'd1_000_010, {32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF});
        send_beat(CMD_PUSH, 48'd1_000_020, {32'h0000_0001, 32'h0000_0002, 32'h0000_0003});
        send_beat(CMD_PUSH, 48'd1_000_030, {32'hFFFF_FFFE, 32'h5555_5555, 32'hAAAA_AAAA});
        // tie keeps newer, newest as first candidate, walk to oldest
        send_beat(CMD_QUERY, 48'd1_000_015, rand_vel());
        send_beat(CMD_QUERY, 48'd1_000_040, rand_vel());
        send_beat(CMD_QUERY, 48'd999_000, rand_vel());
        // window edges at the reset tolerance
        send_beat(CMD_QUERY, 48'd899_999, rand_vel());
        send_beat(CMD_QUERY, 48'd900_000, rand_vel());
        send_beat(CMD_QUERY, 48'd1_100_030, rand_vel());
        send_beat(CMD_QUERY, 48'd1_100_031, rand_vel());
        // out-of-order stamp
        send_beat(CMD_PUSH, 48'd5, rand_vel());
        send_beat(CMD_QUERY, 48'd1_000_020, rand_vel());
        send_beat(CMD_QUERY, 48'd0, rand_vel());
        drain_and_idle();
        set_tolerance('0);
        send_beat(CMD_QUERY, 48'd1_000_000, rand_vel());
        send_beat(CMD_QUERY, 48'd999_999, rand_vel());
        drain_and_idle();
        set_tolerance({TOL_W{1'b1}});
        send_beat(CMD_PUSH, {STAMP_W{1'b1}}, rand_vel());
        send_beat(CMD_QUERY, {STAMP_W{1'b1}}, rand_vel());
        send_beat(CMD_QUERY, '0, rand_vel());
    endtask

    task automatic test_ring_wrap();
        drain_and_idle();
        set_tolerance(TOL_RESET);
        tx_max = 0;
        rx_max = 0;
        stream_now = rand_stamp() >> 8;
        repeat (70)
        begin
            stream_now = stream_now + STAMP_W'($urandom_range(0, 2000));
            send_beat(CMD_PUSH, stream_now, rand_vel());
        end
        repeat (20)
            send_beat(CMD_QUERY, ring_stamp[ring_slot($urandom_range(0, DEPTH - 1))]
                      + STAMP_W'($urandom_range(0, 1000)), rand_vel());
        tx_max = 17;
        rx_max = 17;
    endtask

    task automatic test_input_stall();
        drain_and_idle();
        tx_max = 0;
        rx_hold = 500;
        run_stream(40, 2000, 3000);
        tx_max = 17;
    endtask

    task automatic test_random_traffic();
        drain_and_idle();
        set_tolerance('0);
        run_stream(115, 3000, 4000);
        drain_and_idle();
        set_tolerance({TOL_W{1'b1}});
        tx_max = 0;
        run_stream(115, 400_000, 500_000);
        drain_and_idle();
        set_tolerance(TOL_W'($urandom_range(0, 24'hFF_FFFF)));
        tx_max = 17;
        rx_max = 0;
        run_stream(115, 20_000, 30_000);
        drain_and_idle();
        set_tolerance(TOL_RESET);
        rx_max = 17;
        run_stream(115, 50_000, 80_000);
    endtask

    // result side
    initial
    begin
        int unsigned gap;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            gap = (rx_hold != 0) ? rx_hold : $urandom_range(0, rx_max);
            rx_hold = 0;
            if (gap != 0)
            begin
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            pop <= 1'b1;
            @(posedge clk);
            while (empty)
                @(posedge clk);
            check_lookup();
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb: timed out after %0d cycles", cycle_count);
        $display("tb: done, errors");
        $finish;
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_ring_wrap();
        test_input_stall();
        test_random_traffic();
        drain_and_idle();
        $display("tb: %0d beats in, %0d lookups (found %0d, empty %0d, early %0d, late %0d)",
                 beats_sent, lookups_checked, status_seen[ST_FOUND], status_seen[ST_EMPTY],
                 status_seen[ST_EARLY], status_seen[ST_LATE]);
        $display("tb: %0d input stall cycles, ring wrap and tolerance zero to full scale seen",
                 input_stalls);
        if (mismatch_count == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
